FILE: rtl/core/lfpd_pkg.sv
// shared types, constants and helpers for the line follower pd controller
`timescale 1ns / 1ps

package lfpd_pkg;

   localparam int SENSOR_COUNT       = 5;
   localparam int SAMPLE_BITS        = 10;
   localparam int GAIN_FRACTION_BITS = 8;

   localparam int GAIN_BITS  = 12;
   localparam int CMD_BITS   = 9;
   localparam int PWM_BITS   = 8;
   localparam int ERR_BITS   = 6;
   localparam int SPIN_BITS  = 8;
   localparam int DIR_BITS   = 2;

   localparam int CSR_DATA_BITS  = SENSOR_COUNT * SAMPLE_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam int CMD_LIMIT     = 254;
   localparam int CENTER_WEIGHT = 30;
   localparam int WEIGHT_STEP   = 10;

   // centroid divide: weighted sum times a per-count reciprocal
   localparam int COUNT_BITS   = $clog2(SENSOR_COUNT + 1);
   localparam int WSUM_MAX     = WEIGHT_STEP * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
   localparam int WSUM_BITS    = $clog2(WSUM_MAX + 1);
   localparam int RECIP_SHIFT  = 9;
   localparam int RECIP_BITS   = RECIP_SHIFT + 1;
   localparam int PRODUCT_BITS = WSUM_BITS + RECIP_BITS;
   localparam int QUOT_BITS    = PRODUCT_BITS - RECIP_SHIFT;

   // pd datapath widths
   localparam int PTERM_BITS   = GAIN_BITS + 1 + ERR_BITS;
   localparam int DIFF_BITS    = ERR_BITS + 1;
   localparam int DTERM_BITS   = GAIN_BITS + 1 + DIFF_BITS;
   localparam int TOTAL_BITS   = DTERM_BITS + 1;
   localparam int CORR_BITS    = TOTAL_BITS - GAIN_FRACTION_BITS;
   localparam int CMD_SUM_BITS = CORR_BITS + 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLDS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROP_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_LEFT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_RIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIN_SPEED = 3'd5;

   typedef logic signed [CMD_BITS-1:0] cmd_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef enum logic [1:0] {EDGE_NONE, EDGE_LEFT, EDGE_RIGHT} edge_type;
   typedef enum logic [1:0] {DIR_BRAKE, DIR_FORWARD, DIR_REVERSE} dir_type;
   typedef enum logic [1:0] {ST_IDLE, ST_LANE, ST_MUL, ST_FIN} state_type;

   typedef struct packed {
      err_type err;
      logic    lost;
      logic    left_seen;
      logic    right_seen;
   } line_info_type;

   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] count);
      logic [RECIP_BITS-1:0] r;
      unique case (count)
         3'd1:    r = RECIP_BITS'(2 ** RECIP_SHIFT);
         3'd2:    r = RECIP_BITS'((2 ** RECIP_SHIFT + 1) / 2);
         3'd3:    r = RECIP_BITS'((2 ** RECIP_SHIFT + 2) / 3);
         3'd4:    r = RECIP_BITS'((2 ** RECIP_SHIFT + 3) / 4);
         3'd5:    r = RECIP_BITS'((2 ** RECIP_SHIFT + 4) / 5);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic cmd_type clamp_cmd(input logic signed [CMD_SUM_BITS-1:0] v);
      cmd_type c;
      if (v > CMD_LIMIT) begin
         c = cmd_type'(CMD_LIMIT);
      end else if (v < -CMD_LIMIT) begin
         c = cmd_type'(-CMD_LIMIT);
      end else begin
         c = CMD_BITS'(v);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/lfpd_req_if.sv
// sensor sample channel
`timescale 1ns / 1ps

interface lfpd_req_if;
   import lfpd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_0;
   logic [SAMPLE_BITS-1:0] sample_1;
   logic [SAMPLE_BITS-1:0] sample_2;
   logic [SAMPLE_BITS-1:0] sample_3;
   logic [SAMPLE_BITS-1:0] sample_4;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   output ready);
endinterface

FILE: rtl/core/lfpd_rsp_if.sv
// motor command channel
`timescale 1ns / 1ps

interface lfpd_rsp_if;
   import lfpd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PWM_BITS-1:0]  left_pwm;
   logic [DIR_BITS-1:0]  left_dir;
   logic [PWM_BITS-1:0]  right_pwm;
   logic [DIR_BITS-1:0]  right_dir;
   logic [ERR_BITS-1:0]  line_error;
   logic                 line_lost;

   modport source (output valid, left_pwm, left_dir, right_pwm, right_dir, line_error,
                   line_lost, input ready);
   modport sink   (input valid, left_pwm, left_dir, right_pwm, right_dir, line_error,
                   line_lost, output ready);
endinterface

FILE: rtl/core/lfpd_lane.sv
// one sensor lane: registered threshold compare
`timescale 1ns / 1ps

module lfpd_lane (
   input  logic                            clock,
   input  logic                            load,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0] threshold,
   output logic                            seen
);
   import lfpd_pkg::*;

   logic seen_ff;
   logic seen_in;

   // dark reading below threshold means line
   assign seen_in = sample < threshold;

   always_ff @(posedge clock) begin
      if (load) begin
         seen_ff <= seen_in;
      end
   end

   assign seen = seen_ff;

endmodule

FILE: rtl/core/lfpd_merge.sv
// merges lane hits into the centroid line error
`timescale 1ns / 1ps

module lfpd_merge (
   input  logic                             clock,
   input  logic                             load,
   input  logic [lfpd_pkg::SENSOR_COUNT-1:0] seen,
   output lfpd_pkg::line_info_type          info
);
   import lfpd_pkg::*;

   logic [COUNT_BITS-1:0]   count;
   logic [WSUM_BITS-1:0]    wsum;
   logic [PRODUCT_BITS-1:0] product;
   logic [QUOT_BITS-1:0]    quot;
   logic [ERR_BITS:0]       err_wide;
   line_info_type           info_ff;
   line_info_type           info_in;

   always_comb begin
      count = '0;
      wsum  = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (seen[i]) begin
            count = count + COUNT_BITS'(1);
            wsum  = wsum + WSUM_BITS'((i + 1) * WEIGHT_STEP);
         end
      end
   end

   // floor division by count through a reciprocal, exact over the reachable sums
   always_comb begin
      product  = PRODUCT_BITS'(wsum) * PRODUCT_BITS'(recip_of(count));
      quot     = product[PRODUCT_BITS-1:RECIP_SHIFT];
      err_wide = {1'b0, quot[ERR_BITS-1:0]} - (ERR_BITS + 1)'(CENTER_WEIGHT);

      info_in.lost       = (count == '0);
      info_in.err        = info_in.lost ? '0 : err_type'(err_wide[ERR_BITS-1:0]);
      info_in.left_seen  = seen[0];
      info_in.right_seen = seen[SENSOR_COUNT-1];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

FILE: rtl/core/lfpd_pd.sv
// pd correction: registered gain products, then sum, truncate and clamp
`timescale 1ns / 1ps

module lfpd_pd (
   input  logic                           clock,
   input  logic                           load,
   input  lfpd_pkg::err_type              err,
   input  lfpd_pkg::err_type              prev_err,
   input  logic [lfpd_pkg::GAIN_BITS-1:0] prop_gain,
   input  logic [lfpd_pkg::GAIN_BITS-1:0] deriv_gain,
   input  lfpd_pkg::cmd_type              base_left,
   input  lfpd_pkg::cmd_type              base_right,
   output lfpd_pkg::cmd_type              left_cmd,
   output lfpd_pkg::cmd_type              right_cmd
);
   import lfpd_pkg::*;

   logic signed [PTERM_BITS-1:0]   pg_w;
   logic signed [PTERM_BITS-1:0]   e_w;
   logic signed [DIFF_BITS-1:0]    diff;
   logic signed [DTERM_BITS-1:0]   dg_w;
   logic signed [DTERM_BITS-1:0]   d_w;
   logic signed [PTERM_BITS-1:0]   pterm_in;
   logic signed [DTERM_BITS-1:0]   dterm_in;
   logic signed [PTERM_BITS-1:0]   pterm_ff;
   logic signed [DTERM_BITS-1:0]   dterm_ff;
   logic signed [TOTAL_BITS-1:0]   total;
   logic signed [TOTAL_BITS-1:0]   biased;
   logic signed [CORR_BITS-1:0]    corr;
   logic signed [CMD_SUM_BITS-1:0] left_sum;
   logic signed [CMD_SUM_BITS-1:0] right_sum;

   always_comb begin
      pg_w     = PTERM_BITS'(signed'({1'b0, prop_gain}));
      e_w      = PTERM_BITS'(err);
      pterm_in = pg_w * e_w;
      diff     = DIFF_BITS'(err) - DIFF_BITS'(prev_err);
      dg_w     = DTERM_BITS'(signed'({1'b0, deriv_gain}));
      d_w      = DTERM_BITS'(diff);
      dterm_in = dg_w * d_w;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pterm_ff <= pterm_in;
         dterm_ff <= dterm_in;
      end
   end

   // add the fraction mask before the shift on negatives: truncates toward zero
   always_comb begin
      total  = TOTAL_BITS'(pterm_ff) + TOTAL_BITS'(dterm_ff);
      biased = total + (total[TOTAL_BITS-1] ? TOTAL_BITS'(2 ** GAIN_FRACTION_BITS - 1)
                                            : TOTAL_BITS'(0));
      corr      = biased[TOTAL_BITS-1:GAIN_FRACTION_BITS];
      left_sum  = CMD_SUM_BITS'(base_left) + CMD_SUM_BITS'(corr);
      right_sum = CMD_SUM_BITS'(base_right) - CMD_SUM_BITS'(corr);
      left_cmd  = clamp_cmd(left_sum);
      right_cmd = clamp_cmd(right_sum);
   end

endmodule

FILE: rtl/core/line_follow_pd_controller.sv
// top level of the line follower pd controller
`timescale 1ns / 1ps

// usage
// - req_ch carries one beat of five reflectance samples, sensor 0 leftmost
// - rsp_ch returns one beat per request: pwm and direction per motor, the
//   centroid line error and a line lost flag
// - csr_we/csr_index/csr_wdata write a register, no read-back;
//   write only while no request is in flight
// - a request's beat appears on rsp_ch after lane compare at the accepting
//   edge, then centroid merge, gain multiply and sum/clamp into the output
//   register; the next request can be taken the cycle after the sum/clamp
//   step has loaded the output register, so no new request is taken before
//   the last is through, set by the four-step sequencer with one item in
//   flight
// - five compare lanes run side by side; the merge stage counts hits and
//   divides the weighted sum through a reciprocal table
// - reset (synchronous, active high) restores register defaults, brakes
//   both held commands, clears the previous error and the edge memory
// - a stalled rsp_ch keeps its beat; a finished item waits in the last step
//   until the output register frees up, and no new request is accepted
//   meanwhile
module line_follow_pd_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   lfpd_req_if.sink                               req_ch,
   lfpd_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [lfpd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import lfpd_pkg::*;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] thresholds_ff;
   logic [GAIN_BITS-1:0]     prop_gain_ff;
   logic [GAIN_BITS-1:0]     deriv_gain_ff;
   cmd_type                  base_left_ff;
   cmd_type                  base_right_ff;
   logic [SPIN_BITS-1:0]     spin_speed_ff;

   // controller state
   state_type state_ff;
   state_type state_in;
   edge_type  edge_ff;
   edge_type  edge_in;
   err_type   prev_err_ff;
   cmd_type   held_left_ff;
   cmd_type   held_right_ff;

   // output register
   logic                rsp_valid_ff;
   logic [PWM_BITS-1:0] rsp_left_pwm_ff;
   dir_type             rsp_left_dir_ff;
   logic [PWM_BITS-1:0] rsp_right_pwm_ff;
   dir_type             rsp_right_dir_ff;
   err_type             rsp_err_ff;
   logic                rsp_lost_ff;

   // handshake and step controls
   logic accept;
   logic lane_load;
   logic merge_load;
   logic mul_load;
   logic fin_fire;
   logic rsp_free;

   logic [SAMPLE_BITS-1:0]  samples [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] seen;
   line_info_type           info;
   cmd_type                 pd_left;
   cmd_type                 pd_right;
   cmd_type                 spin_cmd;
   cmd_type                 next_left;
   cmd_type                 next_right;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff <= CSR_DATA_BITS'(50'd467802890260038);
         prop_gain_ff  <= GAIN_BITS'(512);
         deriv_gain_ff <= GAIN_BITS'(102);
         base_left_ff  <= cmd_type'(175);
         base_right_ff <= cmd_type'(175);
         spin_speed_ff <= SPIN_BITS'(100);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLDS: thresholds_ff <= csr_wdata;
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_BASE_LEFT:  base_left_ff  <= csr_wdata[CMD_BITS-1:0];
            CSR_BASE_RIGHT: base_right_ff <= csr_wdata[CMD_BITS-1:0];
            CSR_SPIN_SPEED: spin_speed_ff <= csr_wdata[SPIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_ch.valid) begin
            state_in = ST_LANE;
         end
         ST_LANE: state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN:  if (rsp_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      lane_load    = accept;
      merge_load   = (state_ff == ST_LANE);
      mul_load     = (state_ff == ST_MUL);
      fin_fire     = (state_ff == ST_FIN) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- compare lanes ----------------
   assign samples[0] = req_ch.sample_0;
   assign samples[1] = req_ch.sample_1;
   assign samples[2] = req_ch.sample_2;
   assign samples[3] = req_ch.sample_3;
   assign samples[4] = req_ch.sample_4;

   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
      lfpd_lane u_lane (
         .clock     (clock),
         .load      (lane_load),
         .sample    (samples[g]),
         .threshold (thresholds_ff[g*SAMPLE_BITS +: SAMPLE_BITS]),
         .seen      (seen[g])
      );
   end

   // ---------------- centroid merge ----------------
   lfpd_merge u_merge (
      .clock (clock),
      .load  (merge_load),
      .seen  (seen),
      .info  (info)
   );

   // ---------------- pd correction ----------------
   lfpd_pd u_pd (
      .clock      (clock),
      .load       (mul_load),
      .err        (info.err),
      .prev_err   (prev_err_ff),
      .prop_gain  (prop_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .base_left  (base_left_ff),
      .base_right (base_right_ff),
      .left_cmd   (pd_left),
      .right_cmd  (pd_right)
   );

   // ---------------- command select ----------------
   // spin speed of 255 saturates to the command limit
   assign spin_cmd = (spin_speed_ff > SPIN_BITS'(CMD_LIMIT)) ? cmd_type'(CMD_LIMIT)
                                                            : cmd_type'({1'b0, spin_speed_ff});

   always_comb begin
      if (info.left_seen) begin
         edge_in = EDGE_LEFT;
      end else if (info.right_seen) begin
         edge_in = EDGE_RIGHT;
      end else begin
         edge_in = edge_ff;
      end
   end

   // line lost: spin toward the last edge, or hold the last command
   always_comb begin
      next_left  = held_left_ff;
      next_right = held_right_ff;
      if (!info.lost) begin
         next_left  = pd_left;
         next_right = pd_right;
      end else begin
         case (edge_ff)
            EDGE_LEFT: begin
               next_left  = -spin_cmd;
               next_right = spin_cmd;
            end
            EDGE_RIGHT: begin
               next_left  = spin_cmd;
               next_right = -spin_cmd;
            end
            default: ;
         endcase
      end
   end

   function automatic logic [PWM_BITS-1:0] pwm_of(input cmd_type c);
      cmd_type m;
      m = c[CMD_BITS-1] ? -c : c;
      return m[PWM_BITS-1:0];
   endfunction

   function automatic dir_type dir_of(input cmd_type c);
      dir_type d;
      if (c == '0) begin
         d = DIR_BRAKE;
      end else if (c[CMD_BITS-1]) begin
         d = DIR_REVERSE;
      end else begin
         d = DIR_FORWARD;
      end
      return d;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff       <= EDGE_NONE;
         prev_err_ff   <= '0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else if (fin_fire) begin
         edge_ff       <= edge_in;
         held_left_ff  <= next_left;
         held_right_ff <= next_right;
         if (!info.lost) begin
            prev_err_ff <= info.err;
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         rsp_left_pwm_ff  <= pwm_of(next_left);
         rsp_left_dir_ff  <= dir_of(next_left);
         rsp_right_pwm_ff <= pwm_of(next_right);
         rsp_right_dir_ff <= dir_of(next_right);
         rsp_err_ff       <= info.err;
         rsp_lost_ff      <= info.lost;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.left_pwm   = rsp_left_pwm_ff;
   assign rsp_ch.left_dir   = rsp_left_dir_ff;
   assign rsp_ch.right_pwm  = rsp_right_pwm_ff;
   assign rsp_ch.right_dir  = rsp_right_dir_ff;
   assign rsp_ch.line_error = rsp_err_ff;
   assign rsp_ch.line_lost  = rsp_lost_ff;

   // ---------------- checks ----------------
   a_lost_zero_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_lost_ff |-> rsp_err_ff == '0)
      else $error("line error not zero on a lost-line beat");

   a_pwm_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_left_pwm_ff <= PWM_BITS'(CMD_LIMIT)
                       && rsp_right_pwm_ff <= PWM_BITS'(CMD_LIMIT))
      else $error("pwm beyond command limit");

   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_left_dir_ff == DIR_BRAKE) == (rsp_left_pwm_ff == '0))
                       && ((rsp_right_dir_ff == DIR_BRAKE) == (rsp_right_pwm_ff == '0)))
      else $error("brake direction and zero pwm disagree");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_left_ff <= cmd_type'(CMD_LIMIT) && held_left_ff >= cmd_type'(-CMD_LIMIT)
      && held_right_ff <= cmd_type'(CMD_LIMIT) && held_right_ff >= cmd_type'(-CMD_LIMIT))
      else $error("held command outside saturation range");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished item did not reach the output register");

endmodule

FILE: verif/tb_line_follow_pd_controller.sv
// self-checking testbench for the line follower pd controller
`timescale 1ns / 1ps

module tb_line_follow_pd_controller;
   import lfpd_pkg::*;

   // sensor 0 sits in the lowest bits, same packing as the threshold register
   typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_set_type;

   typedef struct packed {
      logic [PWM_BITS-1:0] left_pwm;
      dir_type             left_dir;
      logic [PWM_BITS-1:0] right_pwm;
      dir_type             right_dir;
      err_type             line_error;
      logic                line_lost;
   } motor_beat_type;

   // hand-picked sensor patterns for the opening part: edges, lost line,
   // spins both ways, both edges at once, centroid shapes of two, three and five sensors
   localparam logic [SENSOR_COUNT-1:0] DIRECTED_MASKS [19] = '{
      5'b00001, 5'b10000, 5'b00000, 5'b00001, 5'b00000, 5'b00000, 5'b10001,
      5'b00011, 5'b00110, 5'b01100, 5'b11000, 5'b00111, 5'b01110, 5'b11100,
      5'b11111, 5'b01010, 5'b10101, 5'b01011, 5'b10000
   };

   localparam logic [CSR_DATA_BITS-1:0] THRESHOLDS_AT_RESET = 50'd467802890260038;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   lfpd_req_if req_ch();
   lfpd_rsp_if rsp_ch();

   line_follow_pd_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers
   logic [CSR_DATA_BITS-1:0] thr_shadow;
   logic [GAIN_BITS-1:0]     kp_shadow;
   logic [GAIN_BITS-1:0]     kd_shadow;
   cmd_type                  base_l_shadow;
   cmd_type                  base_r_shadow;
   logic [SPIN_BITS-1:0]     spin_shadow;

   // steering state mirrored from the block
   edge_type edge_mem;
   err_type  last_err;
   cmd_type  held_l;
   cmd_type  held_r;

   sample_set_type sample_backlog [$];
   motor_beat_type motor_expect [$];

   int  mismatches;
   int  beats_checked;
   int  n_lost;
   int  n_spin;
   int  n_clamped;
   int  n_settings;
   int  gap_left;
   int  stall_left;
   int  next_hold_mark;
   logic calm_tail;

   sample_set_type offered_set;
   motor_beat_type predicted;
   motor_beat_type want;

   // ---------------------------------------------------------------------
   // steering predictor
   // ---------------------------------------------------------------------

   function automatic cmd_type limit_cmd(input int v);
      if (v > CMD_LIMIT || v < -CMD_LIMIT) n_clamped++;
      if (v > CMD_LIMIT) return cmd_type'(CMD_LIMIT);
      if (v < -CMD_LIMIT) return cmd_type'(-CMD_LIMIT);
      return cmd_type'(v);
   endfunction

   function automatic logic [PWM_BITS-1:0] pwm_of(input cmd_type c);
      int v;
      v = c;
      return PWM_BITS'((v < 0) ? -v : v);
   endfunction

   function automatic dir_type heading_of(input cmd_type c);
      if (c == 0) return DIR_BRAKE;
      if (c > 0) return DIR_FORWARD;
      return DIR_REVERSE;
   endfunction

   // one sample set in, one motor beat out; advances the mirrored state
   function automatic motor_beat_type predict_motor_beat(input sample_set_type smp);
      logic [SENSOR_COUNT-1:0] seen;
      logic [SAMPLE_BITS-1:0]  thr;
      int                      hits;
      int                      wsum;
      int                      err;
      int                      total;
      int                      corr;
      motor_beat_type          b;
      hits = 0;
      wsum = 0;
      err  = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         thr     = thr_shadow[i*SAMPLE_BITS +: SAMPLE_BITS];
         seen[i] = smp[i] < thr;
         if (seen[i]) begin
            hits++;
            wsum += (i + 1) * WEIGHT_STEP;
         end
      end
      // left edge wins when both edges see the line
      if (seen[0]) edge_mem = EDGE_LEFT;
      else if (seen[SENSOR_COUNT-1]) edge_mem = EDGE_RIGHT;

      if (hits == 0) begin
         n_lost++;
         if (edge_mem == EDGE_LEFT) begin
            held_l = limit_cmd(-int'(spin_shadow));
            held_r = limit_cmd(int'(spin_shadow));
            n_spin++;
         end else if (edge_mem == EDGE_RIGHT) begin
            held_l = limit_cmd(int'(spin_shadow));
            held_r = limit_cmd(-int'(spin_shadow));
            n_spin++;
         end
         // no edge ever seen: held commands go out again, error memory kept
      end else begin
         err   = wsum / hits - CENTER_WEIGHT;
         total = int'(kp_shadow) * err + int'(kd_shadow) * (err - int'(last_err));
         corr  = total / (1 << GAIN_FRACTION_BITS);
         held_l   = limit_cmd(int'(base_l_shadow) + corr);
         held_r   = limit_cmd(int'(base_r_shadow) - corr);
         last_err = err_type'(err);
      end

      b.left_pwm   = pwm_of(held_l);
      b.left_dir   = heading_of(held_l);
      b.right_pwm  = pwm_of(held_r);
      b.right_dir  = heading_of(held_r);
      b.line_error = err_type'(err);
      b.line_lost  = (hits == 0);
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // samples that put each sensor on or off the line under the current
   // thresholds, leaning on the boundary values now and then
   function automatic sample_set_type shape_samples(input logic [SENSOR_COUNT-1:0] on_line);
      sample_set_type         s;
      logic [SAMPLE_BITS-1:0] thr;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         thr = thr_shadow[i*SAMPLE_BITS +: SAMPLE_BITS];
         if (on_line[i] && thr != 0) begin
            case ($urandom_range(0, 7))
               0:       s[i] = '0;
               1:       s[i] = thr - 1'b1;
               default: s[i] = SAMPLE_BITS'($urandom_range(0, thr - 1));
            endcase
         end else begin
            case ($urandom_range(0, 7))
               0:       s[i] = thr;
               1:       s[i] = '1;
               default: s[i] = SAMPLE_BITS'($urandom_range(thr, 2**SAMPLE_BITS - 1));
            endcase
         end
      end
      return s;
   endfunction

   // mostly a contiguous line under one to three sensors, with lost-line
   // sets mixed in and some scattered patterns and raw noise
   task automatic queue_random(input int n);
      logic [SENSOR_COUNT-1:0] m;
      int                      w;
      int                      r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 9);
         if (r <= 5) begin
            w = $urandom_range(1, 3);
            m = SENSOR_COUNT'(((1 << w) - 1) << $urandom_range(0, SENSOR_COUNT - w));
            sample_backlog.push_back(shape_samples(m));
         end else if (r <= 7) begin
            sample_backlog.push_back(shape_samples('0));
         end else if (r == 8) begin
            sample_backlog.push_back(shape_samples(SENSOR_COUNT'($urandom)));
         end else begin
            sample_backlog.push_back(sample_set_type'({$urandom, $urandom}));
         end
      end
   endtask

   // random bits above the register's width, which the block must ignore
   function automatic logic [CSR_DATA_BITS-1:0] with_junk(input logic [CSR_DATA_BITS-1:0] v,
                                                          input int w);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'({$urandom, $urandom});
      return (junk << w) | v;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_THRESHOLDS: thr_shadow    = value;
         CSR_PROP_GAIN:  kp_shadow     = value[GAIN_BITS-1:0];
         CSR_DERIV_GAIN: kd_shadow     = value[GAIN_BITS-1:0];
         CSR_BASE_LEFT:  base_l_shadow = cmd_type'(value[CMD_BITS-1:0]);
         CSR_BASE_RIGHT: base_r_shadow = cmd_type'(value[CMD_BITS-1:0]);
         CSR_SPIN_SPEED: spin_shadow   = value[SPIN_BITS-1:0];
         default: ;
      endcase
   endtask

   // back-to-back writes of all six registers, only while the block is idle
   task automatic set_regs(input logic [CSR_DATA_BITS-1:0] thr,
                           input logic [GAIN_BITS-1:0] kp, input logic [GAIN_BITS-1:0] kd,
                           input logic [CMD_BITS-1:0] bl, input logic [CMD_BITS-1:0] br,
                           input logic [SPIN_BITS-1:0] spin);
      write_reg(CSR_THRESHOLDS, thr);
      write_reg(CSR_PROP_GAIN, with_junk(kp, GAIN_BITS));
      write_reg(CSR_DERIV_GAIN, with_junk(kd, GAIN_BITS));
      write_reg(CSR_BASE_LEFT, with_junk(bl, CMD_BITS));
      write_reg(CSR_BASE_RIGHT, with_junk(br, CMD_BITS));
      write_reg(CSR_SPIN_SPEED, with_junk(spin, SPIN_BITS));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      n_settings++;
   endtask

   // sender holds back until every expected beat has come home
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_ch.valid || motor_expect.size() != 0);
   endtask

   task automatic flag_mismatch(input string what, input int got, input int exp_val);
      mismatches++;
      $display("mismatch at beat %0d, %s: got %0d, expected %0d",
               beats_checked, what, got, exp_val);
   endtask

   // ---------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // driver: feeds sample sets from the backlog, with random idle bursts
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         // a beat accepted at this edge is predicted from what was on the bus
         if (req_ch.valid && req_ch.ready) begin
            offered_set = {req_ch.sample_4, req_ch.sample_3, req_ch.sample_2,
                           req_ch.sample_1, req_ch.sample_0};
            predicted = predict_motor_beat(offered_set);
            motor_expect.push_back(predicted);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               req_ch.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (!calm_tail && sample_backlog.size() != 0
                         && $urandom_range(0, 4) == 0) begin
               // start an idle burst
               req_ch.valid <= 1'b0;
               gap_left     <= $urandom_range(0, 5);
            end else if (sample_backlog.size() != 0) begin
               offered_set      = sample_backlog.pop_front();
               req_ch.sample_0 <= offered_set[0];
               req_ch.sample_1 <= offered_set[1];
               req_ch.sample_2 <= offered_set[2];
               req_ch.sample_3 <= offered_set[3];
               req_ch.sample_4 <= offered_set[4];
               req_ch.valid    <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts, plus two long hold-offs so the block
   // backs up and stops taking samples
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         stall_left     <= 0;
         next_hold_mark <= 40;
      end else if (beats_checked >= next_hold_mark) begin
         rsp_ch.ready   <= 1'b0;
         stall_left     <= 47;
         next_hold_mark <= (next_hold_mark < 300) ? 300 : 32'h7fff_ffff;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 5);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every accepted motor beat against the oldest prediction
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (motor_expect.size() == 0) begin
            flag_mismatch("beat with nothing expected", 1, 0);
         end else begin
            want = motor_expect.pop_front();
            if (rsp_ch.left_pwm !== want.left_pwm)
               flag_mismatch("left_pwm", rsp_ch.left_pwm, want.left_pwm);
            if (rsp_ch.left_dir !== want.left_dir)
               flag_mismatch("left_dir", rsp_ch.left_dir, want.left_dir);
            if (rsp_ch.right_pwm !== want.right_pwm)
               flag_mismatch("right_pwm", rsp_ch.right_pwm, want.right_pwm);
            if (rsp_ch.right_dir !== want.right_dir)
               flag_mismatch("right_dir", rsp_ch.right_dir, want.right_dir);
            if (rsp_ch.line_error !== want.line_error)
               flag_mismatch("line_error", $signed(rsp_ch.line_error), want.line_error);
            if (rsp_ch.line_lost !== want.line_lost)
               flag_mismatch("line_lost", rsp_ch.line_lost, want.line_lost);
         end
         beats_checked <= beats_checked + 1;
      end
   end

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------

   initial begin
      #2_000_000;
      $display("timeout with %0d beats still expected", motor_expect.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // sequence of phases
   // ---------------------------------------------------------------------

   initial begin
      sample_set_type          edge_set;
      logic [CSR_DATA_BITS-1:0] thr_mix;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.sample_0 = '0;
      req_ch.sample_1 = '0;
      req_ch.sample_2 = '0;
      req_ch.sample_3 = '0;
      req_ch.sample_4 = '0;
      rsp_ch.ready    = 1'b0;
      calm_tail       = 1'b0;
      mismatches      = 0;
      beats_checked   = 0;
      n_lost          = 0;
      n_spin          = 0;
      n_clamped       = 0;
      n_settings      = 1;

      // register values and steering state after reset
      thr_shadow    = THRESHOLDS_AT_RESET;
      kp_shadow     = 12'd512;
      kd_shadow     = 12'd102;
      base_l_shadow = 9'sd175;
      base_r_shadow = 9'sd175;
      spin_shadow   = 8'd100;
      edge_mem      = EDGE_NONE;
      last_err      = '0;
      held_l        = '0;
      held_r        = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: line lost before any edge (held brake), all sensors dark,
      // then edges, spins, centroid shapes, and samples right at the thresholds
      sample_backlog.push_back('1);
      sample_backlog.push_back('0);
      foreach (DIRECTED_MASKS[k]) sample_backlog.push_back(shape_samples(DIRECTED_MASKS[k]));
      edge_set = sample_set_type'(thr_shadow);
      sample_backlog.push_back(edge_set);
      for (int i = 0; i < SENSOR_COUNT; i++) edge_set[i] = edge_set[i] - 1'b1;
      sample_backlog.push_back(edge_set);
      wait_drained();

      // reset register values, random traffic with both long hold-offs ahead
      queue_random(130);
      wait_drained();

      // largest gains, opposite base extremes, spin that saturates
      set_regs(CSR_DATA_BITS'({$urandom, $urandom}), '1, '1, 9'sd254, -9'sd254, 8'd255);
      queue_random(80);
      wait_drained();

      // zero gains, brightest thresholds, zero spin
      set_regs('1, '0, '0, -9'sd254, 9'sd254, 8'd0);
      queue_random(60);
      wait_drained();

      // nothing can see the line; bases beyond the command range
      set_regs('0, 12'($urandom), 12'($urandom), 9'h100, 9'h0ff, 8'($urandom));
      queue_random(30);
      wait_drained();

      // dead and saturated sensors mixed with random ones
      thr_mix = CSR_DATA_BITS'({$urandom, $urandom});
      thr_mix[0 +: SAMPLE_BITS]               = '1;
      thr_mix[SAMPLE_BITS +: SAMPLE_BITS]     = '0;
      thr_mix[4*SAMPLE_BITS +: SAMPLE_BITS]   = 10'd700;
      set_regs(thr_mix, 12'($urandom), 12'($urandom), 9'h101, 9'h0ff, 8'd254);
      queue_random(80);
      wait_drained();

      // closing stretch, random settings, both sides run flat out
      calm_tail = 1'b1;
      set_regs(CSR_DATA_BITS'({$urandom, $urandom}), 12'($urandom), 12'($urandom),
               9'($urandom), 9'($urandom), 8'($urandom));
      queue_random(90);
      wait_drained();

      repeat (8) @(posedge clock);
      $display("checked %0d motor beats over %0d register settings", beats_checked,
               n_settings);
      $display("line lost %0d times, %0d spins, %0d commands clamped", n_lost, n_spin,
               n_clamped);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
